### src/u16ss_pkg.sv
// Shared types and constants for the UTF-16 substring search block.
// No dependencies; imported by utf16_substring_search.
package u16ss_pkg;

  localparam int CharW    = 16;
  localparam int IndexW   = 20;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int PatRegs  = 4;
  localparam int PatChars = 16;

  // configuration register indices
  localparam logic [CfgIdxW-1:0] RegPatLen   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPatWordA = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPatWordB = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPatWordC = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPatWordD = 3'd4;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [IndexW-1:0] match_index;
    logic              too_long;
  } out_item_t;

endpackage

### src/utf16_substring_search.sv
// Top level of the streaming UTF-16 substring search.
// Depends on u16ss_pkg for payload types and register indices.
//
// Usage:
//  - Text enters on in_valid_i / in_stall_o / in_item_i, one code unit per
//    request; last_char closes a text. Results leave on out_valid_o /
//    out_stall_i / out_item_o, exactly one per text: at the first full match
//    or, failing that, at the last character as not-found.
//  - The pattern (length and four 64-bit words of characters) is written over
//    cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i while idle.
//    Unknown indices are ignored.
//  - A request's shifted window is registered on acceptance; the compare runs
//    on that window and its result (if any) goes into the result register.
//  - Throughput: one code unit per cycle unless a stalled result blocks; the window
//    compare is a parallel equality across MAX_PATTERN registered characters.
//  - Reset clears the pattern, the window, the position counter and the
//    output valid flag. No clearing pass.
//  - A stall on the output holds the result register; the compare stage then
//    holds a pending result, so in_stall_o rises only while that result waits.
module utf16_substring_search import u16ss_pkg::*; #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 1048576
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int IW = (CW + 1 > IndexW) ? CW + 1 : IndexW;

  // configuration
  logic [4:0]                         pat_len_q;
  logic [PatRegs-1:0][CfgDataW-1:0]   pat_words_q;

  // text state
  logic [MAX_PATTERN-1:0][CharW-1:0]  win_q, win_d, win_base;
  logic [CW-1:0]                      count_q, count_d, count_base;
  logic                               sat_q, sat_d, sat_base;
  logic                               sent_q, sent_d;

  // compare stage
  logic          a_valid_q, a_valid_d;
  logic          a_last_q;
  logic          a_search_q;
  logic          a_sat_q;
  logic [CW-1:0] a_pos_q;

  // result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic            in_acc, a_adv, text_clear, sat_now, slot_free;
  logic [4:0]      eff_len;
  logic [CharW-1:0] pat_chars [PatChars];
  logic            eq_all, match, found_now, emit;
  logic [CW:0]     pos_plus;
  logic [IW-1:0]   idx_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q   <= '0;
      pat_words_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegPatLen:   pat_len_q      <= cfg_data_i[4:0];
        RegPatWordA: pat_words_q[0] <= cfg_data_i;
        RegPatWordB: pat_words_q[1] <= cfg_data_i;
        RegPatWordC: pat_words_q[2] <= cfg_data_i;
        RegPatWordD: pat_words_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_len = (int'(pat_len_q) > MAX_PATTERN) ? 5'(MAX_PATTERN) : pat_len_q;

  always_comb begin
    for (int j = 0; j < PatChars; j++) begin
      pat_chars[j] = pat_words_q[j >> 2][CharW*(j & 3) +: CharW];
    end
  end

  // window compare: window slot w lines up with pattern char len-1-w
  always_comb begin
    logic [4:0] pidx;
    logic [CharW-1:0] pch;
    eq_all = 1'b1;
    for (int w = 0; w < MAX_PATTERN; w++) begin
      pidx = 5'(int'(eff_len) - 1 - w);
      pch  = pidx[4] ? '0 : pat_chars[pidx[3:0]];
      if (w < int'(eff_len) && win_q[w] != pch) begin
        eq_all = 1'b0;
      end
    end
  end

  assign pos_plus  = {1'b0, a_pos_q} + 1'b1;
  assign match     = a_search_q && (pos_plus >= (CW+1)'(eff_len)) && eq_all;
  assign found_now = match && !sent_q;
  assign emit      = a_valid_q && (found_now || (a_last_q && !sent_q));
  assign idx_full  = (eff_len == '0) ? '0 : (IW'(pos_plus) - IW'(eff_len));

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign a_adv      = a_valid_q && (!emit || slot_free);
  assign in_stall_o = a_valid_q && !a_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign text_clear = a_adv && a_last_q;

  // a request following a closed text starts from cleared state
  assign win_base   = text_clear ? '0 : win_q;
  assign count_base = text_clear ? '0 : count_q;
  assign sat_base   = text_clear ? 1'b0 : sat_q;
  assign sat_now    = count_base >= CW'(MAX_TEXT);

  always_comb begin
    win_d   = win_base;
    count_d = count_base;
    sat_d   = sat_base;
    if (in_acc) begin
      if (sat_now) begin
        sat_d = 1'b1;
      end else begin
        win_d[0] = in_item_i.text_char;
        for (int k = 1; k < MAX_PATTERN; k++) begin
          win_d[k] = win_base[k-1];
        end
        count_d = count_base + 1'b1;
      end
    end
  end

  always_comb begin
    sent_d = sent_q;
    if (a_adv) begin
      if (a_last_q) begin
        sent_d = 1'b0;
      end else if (found_now) begin
        sent_d = 1'b1;
      end
    end
  end

  assign a_valid_d = in_acc || (a_valid_q && !a_adv);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (emit && slot_free) begin
      out_valid_d = 1'b1;
      if (found_now) begin
        out_item_d.found       = 1'b1;
        out_item_d.match_index = idx_full[IndexW-1:0];
        out_item_d.too_long    = 1'b0;
      end else begin
        out_item_d.found       = 1'b0;
        out_item_d.match_index = '0;
        out_item_d.too_long    = a_sat_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      sent_q      <= 1'b0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      count_q     <= count_d;
      sat_q       <= sat_d;
      sent_q      <= sent_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_last_q   <= in_item_i.last_char;
      a_search_q <= !sat_now;
      a_sat_q    <= sat_base || sat_now;
      a_pos_q    <= count_base;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
